>>> sv/gssa_pkg.sv
// gssa_pkg: shared widths, constants and types for the gas sensor score averager
// no dependencies; imported by every module of the block
`default_nettype none
package gssa_pkg;

   localparam int RAW_W     = 12;
   localparam int SCORE_W   = 13;
   localparam int HELD_W    = 5;
   localparam int RES_W     = 17;
   localparam int SUPPLY_W  = 13;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam int VQ_W      = 24;   // divider voltage in 1/4095 mV
   localparam int VS_W      = 26;   // supply in 1/4095 mV
   localparam int NUM_W     = 43;   // ratio numerator / denominator
   localparam int LOGE_W    = 6;
   localparam int LOGF_W    = 16;
   localparam int LOG_W     = LOGE_W + LOGF_W;
   localparam int MANT_W    = 31;
   localparam int CMP_W     = 28;   // signed log-domain compare

   localparam int WINDOW_LEN_DEF = 20;
   localparam int SCORE_MAX      = 8000;
   localparam int VREF_MV        = 3300;
   localparam int ADC_FS         = 4095;
   localparam int MARGIN_MV      = 10;
   localparam int SUPPLY_MIN     = 20;
   localparam int VQ_LO          = 40950;
   localparam int SCORE_REF      = 3200;

   localparam logic [CSR_IDX_W-1:0] CSR_LOAD      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_AIR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY    = 2'd2;

   typedef struct packed {
      logic [RAW_W-1:0] raw;
      logic [VQ_W-1:0]  vq;
   } gssa_item_type;

   typedef struct packed {
      logic          valid;
      gssa_item_type item;
   } gssa_fq_type;

   typedef struct packed {
      logic [RES_W-1:0]    load;
      logic [RES_W-1:0]    clean_air;
      logic [SUPPLY_W-1:0] supply;
   } gssa_cfg_type;

endpackage
`default_nettype wire

>>> sv/gssa_front.sv
// gssa_front: accepts transactions, averages readings, scales to voltage, queues them
// depends on gssa_pkg
`default_nettype none
module gssa_front import gssa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [RAW_W-1:0]   req_first_reading,
   input  logic [RAW_W-1:0]   req_second_reading,
   output gssa_fq_type        fq_head,
   input  logic               fq_pop
);

   localparam int QDEPTH = 2;

   logic [RAW_W:0]   pair_sum;
   logic [RAW_W-1:0] raw_new;
   logic [VQ_W-1:0]  vq_new;
   logic             push;

   gssa_item_type    ent_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign pair_sum = {1'b0, req_first_reading} + {1'b0, req_second_reading};
   assign raw_new  = pair_sum[RAW_W:1];
   assign vq_new   = VQ_W'(raw_new) * VQ_W'(VREF_MV);

   assign req_ready = (cnt_ff != 2'(QDEPTH));
   assign push      = req_valid & req_ready;

   assign fq_head.valid = (cnt_ff != 2'd0);
   assign fq_head.item  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = fq_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(fq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= '{raw: raw_new, vq: vq_new};
      end
   end

endmodule
`default_nettype wire

>>> sv/gssa_log2.sv
// gssa_log2: multi-cycle log2 in q16, normalise then sixteen squaring steps
// depends on gssa_pkg
`default_nettype none
module gssa_log2 import gssa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] x,
   output logic             done,
   output logic [LOG_W-1:0] result
);

   typedef enum logic [2:0] {
      LG_IDLE = 3'b001,
      LG_NORM = 3'b010,
      LG_SQ   = 3'b100
   } gssa_lg_state_type;

   gssa_lg_state_type  state_ff, state_in;
   logic [NUM_W-1:0]   v_ff, v_in;
   logic [LOGE_W-1:0]  e_ff, e_in;
   logic [MANT_W-1:0]  m_ff, m_in;
   logic [LOGF_W-1:0]  frac_ff, frac_in;
   logic [3:0]         step_ff, step_in;
   logic               done_ff, done_in;

   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0]     sq_top;

   // square of the q30 mantissa, brought back to q30
   assign sq     = {{MANT_W{1'b0}}, m_ff} * {{MANT_W{1'b0}}, m_ff};
   assign sq_top = sq[2*MANT_W-1 -: MANT_W+1];

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         LG_IDLE: begin
            if (start) begin
               v_in     = (x == '0) ? NUM_W'(1) : x;
               e_in     = LOGE_W'(NUM_W - 1);
               state_in = LG_NORM;
            end
         end
         LG_NORM: begin
            if (v_ff[NUM_W-1]) begin
               m_in     = v_ff[NUM_W-1 -: MANT_W];
               frac_in  = '0;
               step_in  = 4'd15;
               state_in = LG_SQ;
            end else if (v_ff[NUM_W-1 -: 8] == 8'd0) begin
               v_in = {v_ff[NUM_W-9:0], 8'd0};
               e_in = e_ff - LOGE_W'(8);
            end else begin
               v_in = {v_ff[NUM_W-2:0], 1'b0};
               e_in = e_ff - LOGE_W'(1);
            end
         end
         LG_SQ: begin
            if (sq_top[MANT_W]) begin
               m_in             = sq_top[MANT_W:1];
               frac_in[step_ff] = 1'b1;
            end else begin
               m_in = sq_top[MANT_W-1:0];
            end
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               done_in  = 1'b1;
               state_in = LG_IDLE;
            end
         end
         default: state_in = LG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

endmodule
`default_nettype wire

>>> sv/gssa_back.sv
// gssa_back: sequencer for resistance ratio, log-domain score search, window and mean
// depends on gssa_pkg and gssa_log2
`default_nettype none
module gssa_back import gssa_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  gssa_cfg_type        cfg,
   input  gssa_fq_type         fq_head,
   output logic                fq_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [RAW_W-1:0]    rsp_averaged_raw,
   output logic [SCORE_W-1:0]  rsp_immediate_score,
   output logic [SCORE_W-1:0]  rsp_window_average,
   output logic [HELD_W-1:0]   rsp_samples_held
);

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = SCORE_W + FILL_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   typedef enum logic [15:0] {
      BK_IDLE  = 16'h0001,
      BK_PREP  = 16'h0002,
      BK_CLAMP = 16'h0004,
      BK_MUL   = 16'h0008,
      BK_FLOOR = 16'h0010,
      BK_LN_GO = 16'h0020,
      BK_LN_W  = 16'h0040,
      BK_LD_GO = 16'h0080,
      BK_LD_W  = 16'h0100,
      BK_LC_GO = 16'h0200,
      BK_LC_W  = 16'h0400,
      BK_SR_GO = 16'h0800,
      BK_SR_W  = 16'h1000,
      BK_WIN   = 16'h2000,
      BK_DIV   = 16'h4000,
      BK_OUT   = 16'h8000
   } gssa_bk_state_type;

   gssa_bk_state_type state_ff, state_in;

   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic [VQ_W-1:0]    vq_ff, vq_in;
   logic [VS_W-1:0]    s_ff, s_in;
   logic [VS_W-1:0]    hi_ff, hi_in;
   logic [VS_W-1:0]    diff_ff, diff_in;
   logic [RES_W-1:0]   r0_ff, r0_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   den_ff, den_in;
   logic [LOG_W-1:0]   ln_ff, ln_in;
   logic [LOG_W-1:0]   l3200_ff, l3200_in;
   logic signed [CMP_W-1:0] rhs_ff, rhs_in;
   logic [SCORE_W-1:0] lo_k_ff, lo_k_in;
   logic [SCORE_W-1:0] hi_k_ff, hi_k_in;
   logic [SCORE_W-1:0] mid_ff, mid_in;

   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SCORE_W-1:0] old_ff;
   logic [SCORE_W-1:0] ring [WINDOW_LEN];
   logic               ring_we;

   logic [FILL_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]   dq_ff, dq_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0]   out_raw_ff;
   logic [SCORE_W-1:0] out_score_ff;
   logic [SCORE_W-1:0] out_avg_ff;
   logic [HELD_W-1:0]  out_held_ff;
   logic               out_load;

   // shared log2 unit
   logic               log_start;
   logic [NUM_W-1:0]   log_x;
   logic               log_done;
   logic [LOG_W-1:0]   log_result;

   // scratch
   logic [SUPPLY_W-1:0] supply_eff;
   logic [VQ_W-1:0]     vq_lo_c;
   logic [VQ_W-1:0]     vq_c;
   logic [NUM_W+3:0]    num_x10;
   logic [SCORE_W:0]    mid_sum;
   logic [SCORE_W-1:0]  mid_new;
   logic signed [CMP_W-1:0] ldiff;
   logic signed [CMP_W-1:0] lhs;
   logic [SUM_W-1:0]    sum_new;
   logic [FILL_W:0]     trial;
   logic                trial_ge;

   gssa_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_result)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_averaged_raw    = out_raw_ff;
   assign rsp_immediate_score = out_score_ff;
   assign rsp_window_average  = out_avg_ff;
   assign rsp_samples_held    = out_held_ff;

   assign mid_sum = {1'b0, lo_k_ff} + {1'b0, hi_k_ff} + (SCORE_W+1)'(1);
   assign mid_new = mid_sum[SCORE_W:1];

   assign ldiff = $signed({{(CMP_W-LOG_W){1'b0}}, l3200_ff})
                - $signed({{(CMP_W-LOG_W){1'b0}}, log_result});
   assign lhs   = (ldiff <<< 2) + ldiff;

   assign trial    = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, fill_ff});

   assign out_load = (state_ff == BK_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      raw_in    = raw_ff;
      vq_in     = vq_ff;
      s_in      = s_ff;
      hi_in     = hi_ff;
      diff_in   = diff_ff;
      r0_in     = r0_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      ln_in     = ln_ff;
      l3200_in  = l3200_ff;
      rhs_in    = rhs_ff;
      lo_k_in   = lo_k_ff;
      hi_k_in   = hi_k_ff;
      mid_in    = mid_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      dcnt_in   = dcnt_ff;
      fq_pop    = 1'b0;
      log_start = 1'b0;
      log_x     = num_ff;
      ring_we   = 1'b0;
      sum_new   = sum_ff;

      supply_eff = (cfg.supply < SUPPLY_W'(SUPPLY_MIN)) ? SUPPLY_W'(SUPPLY_MIN) : cfg.supply;
      vq_lo_c    = (vq_ff < VQ_W'(VQ_LO)) ? VQ_W'(VQ_LO) : vq_ff;
      vq_c       = ({{(VS_W-VQ_W){1'b0}}, vq_lo_c} > hi_ff) ? hi_ff[VQ_W-1:0] : vq_lo_c;
      num_x10    = {num_ff, 3'b000} + {2'b00, num_ff, 1'b0};

      unique case (state_ff)
         BK_IDLE: begin
            if (fq_head.valid) begin
               fq_pop   = 1'b1;
               raw_in   = fq_head.item.raw;
               vq_in    = fq_head.item.vq;
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            s_in     = VS_W'(supply_eff) * VS_W'(ADC_FS);
            hi_in    = VS_W'(supply_eff - SUPPLY_W'(MARGIN_MV)) * VS_W'(ADC_FS);
            r0_in    = (cfg.clean_air == '0) ? RES_W'(1) : cfg.clean_air;
            state_in = BK_CLAMP;
         end
         BK_CLAMP: begin
            vq_in    = vq_c;
            diff_in  = s_ff - VS_W'(vq_c);
            state_in = BK_MUL;
         end
         BK_MUL: begin
            num_in   = NUM_W'(diff_ff) * NUM_W'(cfg.load);
            den_in   = NUM_W'(vq_ff) * NUM_W'(r0_ff);
            state_in = BK_FLOOR;
         end
         BK_FLOOR: begin
            // sensor resistance below 0.001 kohm is pinned there
            if (num_x10 < (NUM_W+4)'(vq_ff)) begin
               num_in = NUM_W'(1);
               den_in = NUM_W'(r0_ff) * NUM_W'(10);
            end
            state_in = BK_LN_GO;
         end
         BK_LN_GO: begin
            log_start = 1'b1;
            log_x     = num_ff;
            state_in  = BK_LN_W;
         end
         BK_LN_W: begin
            if (log_done) begin
               ln_in    = log_result;
               state_in = BK_LD_GO;
            end
         end
         BK_LD_GO: begin
            log_start = 1'b1;
            log_x     = den_ff;
            state_in  = BK_LD_W;
         end
         BK_LD_W: begin
            if (log_done) begin
               rhs_in   = ($signed({{(CMP_W-LOG_W){1'b0}}, ln_ff})
                         - $signed({{(CMP_W-LOG_W){1'b0}}, log_result})) <<< 3;
               state_in = BK_LC_GO;
            end
         end
         BK_LC_GO: begin
            log_start = 1'b1;
            log_x     = NUM_W'(SCORE_REF);
            state_in  = BK_LC_W;
         end
         BK_LC_W: begin
            if (log_done) begin
               l3200_in = log_result;
               lo_k_in  = '0;
               hi_k_in  = SCORE_W'(SCORE_MAX);
               state_in = BK_SR_GO;
            end
         end
         BK_SR_GO: begin
            if (lo_k_ff < hi_k_ff) begin
               mid_in    = mid_new;
               log_start = 1'b1;
               log_x     = NUM_W'({mid_new, 1'b0}) - NUM_W'(1);
               state_in  = BK_SR_W;
            end else begin
               state_in = BK_WIN;
            end
         end
         BK_SR_W: begin
            if (log_done) begin
               if (lhs >= rhs_ff) begin
                  lo_k_in = mid_ff;
               end else begin
                  hi_k_in = mid_ff - SCORE_W'(1);
               end
               state_in = BK_SR_GO;
            end
         end
         BK_WIN: begin
            if (fill_ff < FILL_W'(WINDOW_LEN)) begin
               fill_in = fill_ff + FILL_W'(1);
               sum_new = sum_ff + SUM_W'(lo_k_ff);
            end else begin
               sum_new = sum_ff - SUM_W'(old_ff) + SUM_W'(lo_k_ff);
            end
            sum_in  = sum_new;
            ring_we = 1'b1;
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
            rem_in  = '0;
            dq_in   = sum_new;
            dcnt_in = DCNT_W'(SUM_W);
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in  = trial_ge ? FILL_W'(trial - {1'b0, fill_ff}) : trial[FILL_W-1:0];
            dq_in   = {dq_ff[SUM_W-2:0], trial_ge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      vq_ff    <= vq_in;
      s_ff     <= s_in;
      hi_ff    <= hi_in;
      diff_ff  <= diff_in;
      r0_ff    <= r0_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      ln_ff    <= ln_in;
      l3200_ff <= l3200_in;
      rhs_ff   <= rhs_in;
      lo_k_ff  <= lo_k_in;
      hi_k_ff  <= hi_k_in;
      mid_ff   <= mid_in;
      rem_ff   <= rem_in;
      dq_ff    <= dq_in;
      dcnt_ff  <= dcnt_in;
      if (out_load) begin
         out_raw_ff   <= raw_ff;
         out_score_ff <= lo_k_ff;
         out_avg_ff   <= dq_ff[SCORE_W-1:0];
         out_held_ff  <= HELD_W'(fill_ff);
      end
   end

   // score window store
   always_ff @(posedge clock) begin
      old_ff <= ring[slot_ff];
      if (ring_we) begin
         ring[slot_ff] <= lo_k_ff;
      end
   end

endmodule
`default_nettype wire

>>> sv/gas_sensor_score_averager.sv
// gas_sensor_score_averager: top level, csr registers, front/back split and checks
// depends on gssa_pkg, gssa_front, gssa_back
// the shared log2 unit serves the log evaluations of a transaction one after another
// (up to 16 evaluations per transaction, each a normalisation and sixteen squaring steps)
// the back holds one transaction at a time; the front queues two more meanwhile
// reset: synchronous, clears window fill, running sum, queue and result valid, loads default config
`default_nettype none
module gas_sensor_score_averager import gssa_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [RAW_W-1:0]      req_first_reading,
   input  logic [RAW_W-1:0]      req_second_reading,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RAW_W-1:0]      rsp_averaged_raw,
   output logic [SCORE_W-1:0]    rsp_immediate_score,
   output logic [SCORE_W-1:0]    rsp_window_average,
   output logic [HELD_W-1:0]     rsp_samples_held,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // configuration registers; the user must write them only while idle, the block does not enforce it
   gssa_cfg_type cfg_ff, cfg_in;

   // front to back queue head and pop
   gssa_fq_type  fq_head;
   logic         fq_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOAD:      cfg_in.load      = csr_wdata[RES_W-1:0];
            CSR_CLEAN_AIR: cfg_in.clean_air = csr_wdata[RES_W-1:0];
            CSR_SUPPLY:    cfg_in.supply    = csr_wdata[SUPPLY_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.load      <= RES_W'(1000);
         cfg_ff.clean_air <= RES_W'(1000);
         cfg_ff.supply    <= SUPPLY_W'(VREF_MV);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: average, scale to voltage, queue the transaction
   gssa_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_reading  (req_first_reading),
      .req_second_reading (req_second_reading),
      .fq_head            (fq_head),
      .fq_pop             (fq_pop)
   );

   // back: ratio, score search, window update and mean
   gssa_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .fq_head             (fq_head),
      .fq_pop              (fq_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_averaged_raw    (rsp_averaged_raw),
      .rsp_immediate_score (rsp_immediate_score),
      .rsp_window_average  (rsp_window_average),
      .rsp_samples_held    (rsp_samples_held)
   );

   // back only takes from a non-empty queue
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      fq_pop |-> fq_head.valid)
      else $error("queue popped while empty");

   // one transaction in flight in the back
   a_pop_spacing : assert property (@(posedge clock) disable iff (reset)
      fq_pop |=> !fq_pop)
      else $error("back took two transactions in a row");

   // scores stay saturated
   a_score_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_immediate_score <= SCORE_W'(SCORE_MAX))
                 && (rsp_window_average <= SCORE_W'(SCORE_MAX)))
      else $error("score above saturation");

endmodule
`default_nettype wire

>>> dv/gas_sensor_score_averager_tb.sv
// gas_sensor_score_averager_tb: self-checking bench for the gas sensor score averager
// holds its own score predictor and window model; depends on gssa_pkg and the block
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_score_averager_tb;
   import gssa_pkg::*;

   localparam int WIN         = WINDOW_LEN_DEF;
   localparam int STALL_LIMIT = 40000;

   typedef struct {
      logic [RAW_W-1:0]   avg_raw;
      logic [SCORE_W-1:0] score;
      logic [SCORE_W-1:0] win_avg;
      logic [HELD_W-1:0]  held;
   } reading_result_type;

   // log2 in Q16 by repeated squaring of a Q30 mantissa
   function automatic longint log2_q16(longint unsigned x);
      int e;
      longint unsigned m;
      int unsigned frac;
      e = 0;
      frac = 0;
      if (x == 0) x = 1;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      if (e <= 30) m = x << (30 - e);
      else m = x >> (e - 30);
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | (32'd1 << i);
         end
      end
      return longint'(e) * 65536 + longint'(frac);
   endfunction

   class score_board;
      bit [RES_W-1:0]    load_res;
      bit [RES_W-1:0]    clean_res;
      bit [SUPPLY_W-1:0] supply_mv;
      int unsigned ring[WIN];
      int unsigned slot, filled, running_sum;
      int errors;
      reading_result_type pending[$];

      function void clear();
         load_res = 1000; clean_res = 1000; supply_mv = 3300;
         slot = 0; filled = 0; running_sum = 0; errors = 0;
         pending.delete();
      endfunction

      function int unsigned score_for(longint unsigned num, longint unsigned den);
         longint rhs, lhs, l3200;
         int unsigned lo, hi, mid;
         rhs = 8 * (log2_q16(num) - log2_q16(den));
         l3200 = log2_q16(SCORE_REF);
         lo = 0; hi = SCORE_MAX;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 5 * (l3200 - log2_q16(2 * mid - 1));
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      // note an accepted sample and queue the result it must produce
      function void note_sample(bit [RAW_W-1:0] a, bit [RAW_W-1:0] b);
         reading_result_type r;
         int unsigned raw, sup, r0, sc;
         longint unsigned s, vq, vhi, num, den;
         raw = (a + b) >> 1;
         sup = supply_mv < SUPPLY_MIN ? SUPPLY_MIN : supply_mv;
         r0 = clean_res == 0 ? 1 : clean_res;
         s = longint'(sup) * ADC_FS;
         vq = longint'(raw) * VREF_MV;
         vhi = longint'(sup - MARGIN_MV) * ADC_FS;
         if (vq < VQ_LO) vq = VQ_LO;
         if (vq > vhi) vq = vhi;
         num = (s - vq) * load_res;
         // resistance floor at 0.001 kilo-ohm
         if (num * 10 < vq) begin
            num = 1; den = 10 * r0;
         end else den = vq * r0;
         sc = score_for(num, den);
         if (filled < WIN) filled++;
         else running_sum -= ring[slot];
         running_sum += sc;
         ring[slot] = sc;
         slot = (slot + 1 >= WIN) ? 0 : slot + 1;
         r.avg_raw = RAW_W'(raw);
         r.score = SCORE_W'(sc);
         r.win_avg = SCORE_W'(running_sum / filled);
         r.held = HELD_W'(filled);
         pending.push_back(r);
      endfunction

      function void check_result(reading_result_type got);
         reading_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result raw=%0d", $time, got.avg_raw);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.avg_raw !== exp_r.avg_raw) begin
            $display("%0t: averaged_raw exp %0d got %0d", $time, exp_r.avg_raw, got.avg_raw);
            errors++;
         end
         if (got.score !== exp_r.score) begin
            $display("%0t: immediate_score exp %0d got %0d", $time, exp_r.score, got.score);
            errors++;
         end
         if (got.win_avg !== exp_r.win_avg) begin
            $display("%0t: window_average exp %0d got %0d", $time, exp_r.win_avg,
                     got.win_avg);
            errors++;
         end
         if (got.held !== exp_r.held) begin
            $display("%0t: samples_held exp %0d got %0d", $time, exp_r.held, got.held);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [RAW_W-1:0] req_first_reading = 0;
   logic [RAW_W-1:0] req_second_reading = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [RAW_W-1:0] rsp_averaged_raw;
   logic [SCORE_W-1:0] rsp_immediate_score, rsp_window_average;
   logic [HELD_W-1:0] rsp_samples_held;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LOAD;
   logic [CSR_W-1:0] csr_wdata = 0;

   score_board board;
   int sender_idle_pct = 0;     // chance in a hundred the sender holds off
   int receiver_stall_pct = 0;  // chance in a hundred the receiver stalls
   int quiet_cycles = 0;

   gas_sensor_score_averager uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // result side: random stalls, check every accepted transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result('{rsp_averaged_raw, rsp_immediate_score,
                                 rsp_window_average, rsp_samples_held});
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // watchdog: counts cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one transaction in; random idle cycles come first, valid stays up afterwards
   task automatic send_sample(input logic [RAW_W-1:0] a, input logic [RAW_W-1:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_first_reading <= a;
      req_second_reading <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(a, b);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);   // let the log2 unit settle
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      case (idx)
         CSR_LOAD:      board.load_res = RES_W'(value);
         CSR_CLEAN_AIR: board.clean_res = RES_W'(value);
         default:       board.supply_mv = SUPPLY_W'(value);
      endcase
   endtask

   task automatic set_config(input int unsigned ld, input int unsigned ca,
                             input int unsigned sup);
      wait_drained();
      write_reg(CSR_LOAD, ld);
      write_reg(CSR_CLEAN_AIR, ca);
      write_reg(CSR_SUPPLY, sup);
      csr_write_enable <= 0;
   endtask

   // mostly mid-range readings, with a share at the rails
   function automatic logic [RAW_W-1:0] pick_reading();
      case ($urandom_range(9))
         0: return RAW_W'(0);
         1: return RAW_W'(4095);
         2: return RAW_W'($urandom_range(30));
         default: return RAW_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         logic [RAW_W-1:0] a;
         a = pick_reading();
         // paired readings usually sit close together
         if ($urandom_range(3) != 0) send_sample(a, a ^ RAW_W'($urandom_range(15)));
         else send_sample(a, pick_reading());
      end
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: rails, floors and saturation at reset settings
      send_sample(0, 0);
      send_sample(4095, 4095);
      send_sample(4095, 4094);
      send_sample(1, 0);
      send_sample(12'hAAA, 12'h555);
      send_sample(12'h555, 12'hAAA);
      send_sample(2047, 2048);
      send_sample(13, 12);
      for (int i = 0; i < 14; i++)
         send_sample(RAW_W'(i * 290), RAW_W'(4095 - i * 290)); // fill past window
      // zero load hits the resistance floor; zero clean air and low supply clamp
      set_config(0, 0, 5);
      send_sample(2000, 2100);
      send_sample(4095, 0);
      set_config(100000, 1, 5000);
      send_sample(100, 200);
      send_sample(4000, 4095);

      // random phases across settings and idling patterns
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         case (ph)
            0: set_config(1000, 1000, 3300);
            1: set_config(1, 100000, 100);
            2: set_config(100000, 1, 5000);
            3: set_config(1, 1, 100);
            4: set_config(100000, 100000, 5000);
            default: set_config($urandom_range(100000, 1), $urandom_range(100000, 1),
                                $urandom_range(5000, 100));
         endcase
         random_phase(150);
      end
      // full masks on every register
      set_config(17'h1FFFF, 17'h1FFFF, 13'h1FFF);
      random_phase(20);

      wait_drained();
      if (board.errors == 0 && board.pending.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire
